FILE: rtl/rbps_pkg.sv
// ----------------------------------------------------------------------------
// rbps_pkg
// shared constants and types of the byte ring with pattern search
// ----------------------------------------------------------------------------
package rbps_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int MAX_PATTERN_DEF = 8;

	localparam int MODE_W = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_EMPTY  = 2'd2
	} mode_t;

endpackage

FILE: rtl/ring_buffer_pattern_search.sv
// ----------------------------------------------------------------------------
// ring_buffer_pattern_search
// byte ring of the last DEPTH bytes with first-occurrence pattern search
// ----------------------------------------------------------------------------
// One command beat enters on the s_ side and one result beat leaves on the
// m_ side for each command. A command appends a byte, searches the held
// bytes (oldest to newest) for a pattern of up to MAX_PATTERN bytes, or
// empties the ring. Every result carries found, the slot of the match start
// and the fill count after the command.
// Append, empty and the unused mode go from the accept to the deliver state,
// which raises m_tvalid once the output register is free. A search reads one
// held byte per cycle from the ring memory into a window register and compares
// the window against the whole pattern in one compare unit; a search that
// cannot match (empty pattern, pattern longer than the contents) goes straight
// to the deliver state. s_tready is high only while no command is in progress,
// so a new command is taken only after the last has left the deliver state.
// A result waits in the output register while m_tready is low; the next
// command is accepted meanwhile and its result is held until the output frees.
// Reset empties the ring at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_buffer_pattern_search #(
	parameter int DEPTH       = rbps_pkg::DEPTH_DEF,
	parameter int MAX_PATTERN = rbps_pkg::MAX_PATTERN_DEF,
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW         = $clog2(DEPTH + 1),
	localparam int PW         = rbps_pkg::BYTE_W * MAX_PATTERN,
	localparam int IN_W       = rbps_pkg::MODE_W + rbps_pkg::BYTE_W + PW + rbps_pkg::LEN_W,
	localparam int IN_DW      = 8 * ((IN_W + 7) / 8),
	localparam int OUT_W      = 1 + AW + CW,
	localparam int OUT_DW     = 8 * ((OUT_W + 7) / 8)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_DW-1:0]  s_tdata,  // mode, data_byte, pattern, pattern_length
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_DW-1:0] m_tdata   // found, match_slot, fill_count
);

	localparam int LW    = $clog2(MAX_PATTERN + 1);
	localparam int CMP_W = (CW > rbps_pkg::LEN_W) ? CW : rbps_pkg::LEN_W;
	localparam int BW    = rbps_pkg::BYTE_W;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_SEARCH  = 3'b010,
		ST_DELIVER = 3'b100
	} state_t;

	state_t state_q;

	logic [BW-1:0] mem_q [DEPTH];

	logic [AW-1:0] oldest_q, newest_q;
	logic          vacant_q;
	logic [CW-1:0] fill_q;

	logic [AW-1:0]          rd_ptr_q, start_ptr_q;
	logic [CW-1:0]          rd_cnt_q, wcnt_q;
	logic [LW-1:0]          len_q;
	logic [PW-1:0]          pat_q, window_q;
	logic [MAX_PATTERN-1:0] mask_q;
	logic [BW-1:0]          rd_data_s1;
	logic                   rd_vld_s1;

	logic          res_found_q;
	logic [AW-1:0] res_slot_q;

	logic          m_tvalid_q, m_found_q;
	logic [AW-1:0] m_slot_q;
	logic [CW-1:0] m_fill_q;

	rbps_pkg::mode_t             in_mode;
	logic [BW-1:0]               in_byte;
	logic [PW-1:0]               in_pattern;
	logic [rbps_pkg::LEN_W-1:0]  in_len;
	logic [LW-1:0]               len_c, off_c;
	logic                        accept;
	logic                        no_match_c;
	logic [MAX_PATTERN-1:0]      byte_eq;
	logic                        match;
	logic                        win_full;
	logic                        issue;
	logic                        deliver;
	logic [AW-1:0]               newest_nx, oldest_nx;

	assign in_mode    = rbps_pkg::mode_t'(s_tdata[rbps_pkg::MODE_W-1:0]);
	assign in_byte    = s_tdata[rbps_pkg::MODE_W +: BW];
	assign in_pattern = s_tdata[rbps_pkg::MODE_W + BW +: PW];
	assign in_len     = s_tdata[rbps_pkg::MODE_W + BW + PW +: rbps_pkg::LEN_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign len_c = (in_len > rbps_pkg::LEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
	                                                          : LW'(in_len);
	assign off_c = LW'(MAX_PATTERN) - len_c;
	assign no_match_c = (len_c == '0) || (CMP_W'(len_c) > CMP_W'(fill_q));

	assign newest_nx = (newest_q == AW'(DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign oldest_nx = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	// pattern compare against the window, newest byte on top
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			byte_eq[j] = !mask_q[j] || (window_q[BW*j +: BW] == pat_q[BW*j +: BW]);
		end
	end
	assign match    = &byte_eq;
	assign win_full = CMP_W'(wcnt_q) >= CMP_W'(len_q);
	assign issue    = (state_q == ST_SEARCH) && (rd_cnt_q < fill_q);
	assign deliver  = (state_q == ST_DELIVER) && (!m_tvalid_q || m_tready);

	// ring memory
	always_ff @(posedge clk) begin
		if (accept && in_mode == rbps_pkg::MODE_APPEND) begin
			mem_q[vacant_q ? oldest_q : newest_nx] <= in_byte;
		end
		rd_data_s1 <= mem_q[rd_ptr_q];
	end

	// search datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pat_q  <= in_pattern << (BW * off_c);
			mask_q <= {MAX_PATTERN{1'b1}} << off_c;
			len_q  <= len_c;
		end
		if (state_q == ST_SEARCH && rd_vld_s1) begin
			window_q <= {rd_data_s1, window_q[PW-1:BW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			newest_q    <= '0;
			vacant_q    <= 1'b1;
			fill_q      <= '0;
			rd_ptr_q    <= '0;
			start_ptr_q <= '0;
			rd_cnt_q    <= '0;
			wcnt_q      <= '0;
			rd_vld_s1   <= 1'b0;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			m_tvalid_q  <= 1'b0;
			m_found_q   <= 1'b0;
			m_slot_q    <= '0;
			m_fill_q    <= '0;
		end else begin
			if (deliver) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						res_slot_q  <= '0;
						state_q     <= (in_mode == rbps_pkg::MODE_SEARCH && !no_match_c)
						               ? ST_SEARCH : ST_DELIVER;
						case (in_mode)
							rbps_pkg::MODE_APPEND: begin
								if (vacant_q) begin
									newest_q <= oldest_q;
									vacant_q <= 1'b0;
									fill_q   <= CW'(1);
								end else begin
									newest_q <= newest_nx;
									if (newest_nx == oldest_q) begin
										oldest_q <= oldest_nx;
									end else begin
										fill_q <= fill_q + 1'b1;
									end
								end
							end
							rbps_pkg::MODE_SEARCH: begin
								rd_ptr_q    <= oldest_q;
								start_ptr_q <= oldest_q;
								rd_cnt_q    <= '0;
								wcnt_q      <= '0;
							end
							rbps_pkg::MODE_EMPTY: begin
								vacant_q <= 1'b1;
								fill_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (issue) begin
						rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (rd_vld_s1) begin
						wcnt_q <= wcnt_q + 1'b1;
						if (win_full) begin
							start_ptr_q <= (start_ptr_q == AW'(DEPTH - 1)) ? '0
							                                               : start_ptr_q + 1'b1;
						end
					end
					if (win_full && match) begin
						res_found_q <= 1'b1;
						res_slot_q  <= start_ptr_q;
						state_q     <= ST_DELIVER;
					end else if (wcnt_q == fill_q) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (deliver) begin
						m_found_q  <= res_found_q;
						m_slot_q   <= res_slot_q;
						m_fill_q   <= fill_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DW'({m_fill_q, m_slot_q, m_found_q});

	a_fill_tracks_vacant: assert property (@(posedge clk) disable iff (!arst_n)
		vacant_q == (fill_q == '0))
		else $error("fill count disagrees with vacant flag");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(DEPTH))
		else $error("fill count above depth");

	a_found_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DELIVER && res_found_q) |-> CMP_W'(fill_q) >= CMP_W'(len_q))
		else $error("match reported with fewer bytes than the pattern");

	a_reads_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (rd_cnt_q <= fill_q && wcnt_q <= rd_cnt_q))
		else $error("search read more bytes than held");

endmodule

FILE: bench/tb_ring_buffer_pattern_search.sv
// ----------------------------------------------------------------------------
// tb_ring_buffer_pattern_search
// self-checking bench for the byte ring with first-occurrence pattern search
// ----------------------------------------------------------------------------
// Commands go in on the s_ stream and results come back on the m_ stream. A
// scoreboard keeps its own copy of the ring and predicts found, match slot and
// fill count for each accepted command; every result beat is checked in order.
// A short directed list hits the corner cases: search on an empty ring, empty
// and overlong patterns, patterns longer than the contents, emptying and the
// unused mode. Random commands follow, with many searches built from bytes
// that are really held so that hits, misses by one byte and matches that wrap
// around the ring all occur. Two of three phases stall both sides at random.
// ----------------------------------------------------------------------------
module tb_ring_buffer_pattern_search;

	localparam int RING_DEPTH  = rbps_pkg::DEPTH_DEF;
	localparam int PAT_BYTES   = rbps_pkg::MAX_PATTERN_DEF;
	localparam logic [rbps_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic       found;
		logic [5:0] match_slot;
		logic [6:0] fill_count;
	} search_result_t;

	class ring_search_scoreboard;
		logic [7:0]     ring [RING_DEPTH];
		int unsigned    oldest;
		int unsigned    newest;
		bit             vacant;
		search_result_t expected [$];
		int             fail_count;
		int             n_append, n_overwrite, n_search, n_hit, n_empty, n_unused;
		int unsigned    peak_fill;

		function new();
			foreach (ring[i]) ring[i] = 8'h00;
			oldest = 0;
			newest = 0;
			vacant = 1;
			fail_count = 0;
			n_append = 0; n_overwrite = 0; n_search = 0;
			n_hit = 0; n_empty = 0; n_unused = 0;
			peak_fill = 0;
		endfunction

		function int unsigned fill_level();
			if (vacant) return 0;
			if (newest >= oldest) return newest - oldest + 1;
			return RING_DEPTH - oldest + newest + 1;
		endfunction

		function logic [7:0] held_byte(int unsigned idx);
			return ring[(oldest + idx) % RING_DEPTH];
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_command(logic [1:0] mode, logic [7:0] data, logic [63:0] pat,
			logic [3:0] len);
			search_result_t r;
			int unsigned    n, fill, s, k;
			bit             ok;
			r = '0;
			case (mode)
				rbps_pkg::MODE_APPEND: begin
					n_append++;
					if (vacant) begin
						newest = oldest;
						vacant = 0;
					end else begin
						newest = (newest + 1) % RING_DEPTH;
						if (newest == oldest) begin
							oldest = (oldest + 1) % RING_DEPTH;
							n_overwrite++;
						end
					end
					ring[newest] = data;
				end
				rbps_pkg::MODE_SEARCH: begin
					n_search++;
					n = (len > PAT_BYTES) ? PAT_BYTES : len;
					fill = fill_level();
					if (n > 0 && n <= fill) begin
						for (s = 0; s + n <= fill && !r.found; s++) begin
							ok = 1;
							for (k = 0; k < n; k++)
								if (held_byte(s + k) != pat[8*k +: 8]) ok = 0;
							if (ok) begin
								r.found = 1;
								r.match_slot = 6'((oldest + s) % RING_DEPTH);
							end
						end
					end
					if (r.found) n_hit++;
				end
				rbps_pkg::MODE_EMPTY: begin
					n_empty++;
					vacant = 1;
				end
				default: n_unused++;
			endcase
			r.fill_count = 7'(fill_level());
			if (fill_level() > peak_fill) peak_fill = fill_level();
			expected.push_back(r);
		endfunction

		function void check_result(logic found, logic [5:0] slot, logic [6:0] fill);
			search_result_t e;
			if (expected.size() == 0) begin
				$error("result beat with no command outstanding");
				fail_count++;
				return;
			end
			e = expected.pop_front();
			if (found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, found);
				fail_count++;
			end
			if (slot !== e.match_slot) begin
				$error("match_slot: expected %0d, got %0d", e.match_slot, slot);
				fail_count++;
			end
			if (fill !== e.fill_count) begin
				$error("fill_count: expected %0d, got %0d", e.fill_count, fill);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // mode, data_byte, pattern, pattern_length
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // found, match_slot, fill_count

	ring_search_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;

	ring_buffer_pattern_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[0], m_tdata[6:1], m_tdata[13:7]);
	end

	task automatic send_command(input logic [1:0] mode, input logic [7:0] data,
		input logic [63:0] pat, input logic [3:0] len);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, len, pat, data, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(mode, data, pat, len);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] noise64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_command();
		int unsigned      pick, fill, start, k;
		logic [63:0]      pat;
		logic [7:0]       data;
		logic [3:0]       len;
		pick = $urandom_range(0, 99);
		pat  = noise64();
		data = 8'($urandom);
		len  = 4'($urandom);
		if (pick < 52) begin
			if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 3));
			send_command(rbps_pkg::MODE_APPEND, data, pat, len);
		end else if (pick < 90) begin
			fill = sb.fill_level();
			len  = 4'($urandom_range(1, PAT_BYTES));
			if (fill > 0 && $urandom_range(0, 99) < 60) begin
				start = $urandom_range(0, fill - 1);
				for (k = 0; k < len; k++)
					if (start + k < fill) pat[8*k +: 8] = sb.held_byte(start + k);
				if ($urandom_range(0, 4) == 0)
					pat[8*$urandom_range(0, len - 1) +: 8] ^= 8'h01 << $urandom_range(0, 7);
			end else begin
				for (k = 0; k < PAT_BYTES; k++) pat[8*k +: 8] = 8'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 9) == 0) len = 4'($urandom_range(0, 15));
			send_command(rbps_pkg::MODE_SEARCH, data, pat, len);
		end else if (pick < 91) begin
			send_command(rbps_pkg::MODE_EMPTY, data, pat, len);
		end else if (pick < 93) begin
			send_command(MODE_UNUSED, data, pat, len);
		end else begin
			send_command(rbps_pkg::MODE_SEARCH, data, pat, len);
		end
	endtask

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
		send_idle_pct = tx_pct;
		recv_idle_pct = rx_pct;
		repeat (n) begin
			random_command();
			if ($urandom_range(0, 199) == 0) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		sb = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		send_idle_pct = 36;
		recv_idle_pct = 71;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corner cases
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0, 4'd1);
		send_command(MODE_UNUSED, 8'hff, 64'hffff_ffff_ffff_ffff, 4'd15);
		send_command(rbps_pkg::MODE_APPEND, 8'h00, noise64(), 4'd0);
		send_command(rbps_pkg::MODE_APPEND, 8'hff, noise64(), 4'd15);
		send_command(rbps_pkg::MODE_APPEND, 8'h5a, noise64(), 4'd7);
		send_command(rbps_pkg::MODE_APPEND, 8'ha5, noise64(), 4'd8);
		send_command(rbps_pkg::MODE_SEARCH, 8'hff, 64'h0, 4'd0);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'hffff_ffff_ffff_ff00, 4'd2);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_00a5, 4'd1);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'hffff_ffff_a55a_ff00, 4'd4);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_a55a_ff00, 4'd5);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_a55a_ff00, 4'd15);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_5aff, 4'd2);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_005b, 4'd1);
		send_command(rbps_pkg::MODE_EMPTY, 8'hff, 64'hffff_ffff_ffff_ffff, 4'd15);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0, 4'd1);
		send_command(rbps_pkg::MODE_APPEND, 8'hab, 64'h0, 4'd0);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_00ab, 4'd1);
		send_command(rbps_pkg::MODE_APPEND, 8'hcd, 64'h0, 4'd0);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_cdab, 4'd8);
		send_command(rbps_pkg::MODE_SEARCH, 8'h00, 64'h0000_0000_0000_cdab, 4'd2);
		send_command(MODE_UNUSED, 8'h00, 64'h0, 4'd0);
		wait_drained();

		run_phase(400, 36, 71);
		run_phase(400, 71, 36);
		run_phase(400, 0, 0);

		repeat (100) @(posedge clk);
		$display("ran %0d appends (%0d overwrote the oldest byte) and %0d searches (%0d hits)",
			sb.n_append, sb.n_overwrite, sb.n_search, sb.n_hit);
		$display("plus %0d empties and %0d unused-mode commands; highest fill %0d",
			sb.n_empty, sb.n_unused, sb.peak_fill);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rbps_pkg.sv
rtl/ring_buffer_pattern_search.sv
bench/tb_ring_buffer_pattern_search.sv
